// ----- rtl/core/tlah_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-level alarm package
// Word types, phase and level codes and register indexes shared by the
// alarm unit and its environment.
// ----------------------------------------------------------------------------
package tlah_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 16;

    localparam logic [2:0] PH_DISARMED = 3'd0;
    localparam logic [2:0] PH_ARMED    = 3'd1;
    localparam logic [2:0] PH_PENDING  = 3'd2;
    localparam logic [2:0] PH_ACTIVE   = 3'd3;
    localparam logic [2:0] PH_CLEARING = 3'd4;

    localparam logic [1:0] LV_NONE = 2'd0;
    localparam logic [1:0] LV_WARN = 2'd1;
    localparam logic [1:0] LV_CRIT = 2'd2;

    localparam logic [CfgIndexWidth-1:0] REG_WARN_TRIP     = 3'd0;
    localparam logic [CfgIndexWidth-1:0] REG_WARN_RELEASE  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] REG_WARN_HOLD_MS  = 3'd2;
    localparam logic [CfgIndexWidth-1:0] REG_CRIT_TRIP     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] REG_CRIT_RELEASE  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] REG_CRIT_HOLD_MS  = 3'd5;
    localparam logic [CfgIndexWidth-1:0] REG_CRIT_LATCHES  = 3'd6;
    localparam logic [CfgIndexWidth-1:0] REG_TRIP_LOW_SIDE = 3'd7;

    typedef struct packed {
        logic               enabled;
        logic signed [15:0] sample;
        logic [31:0]        time_ms;
    } tlah_in_t;

    typedef struct packed {
        logic [1:0] alert_level;
        logic [2:0] alert_phase;
    } tlah_out_t;

endpackage

// ----- rtl/core/two_level_alarm_with_hysteresis_unit.sv -----
// ----------------------------------------------------------------------------
// Two-level alarm with hysteresis and hold delay
// Compares each signed Q11.4 sample against warning and critical thresholds
// and reports the alarm level and phase for every input word.
// ----------------------------------------------------------------------------
// The unit takes one input word per clock cycle and returns one result word
// for each, in the cycle after acceptance, in order. The whole phase update
// is a single pass of compare logic plus one 32-bit wrapping subtract for
// the elapsed hold time, so the output register is the only stage and input
// ready stays high while the result register is empty or being taken. The
// user is to write thresholds and hold times through the register port while
// the unit is idle; not enforced. All but the result register reset to zero.
module two_level_alarm_with_hysteresis_unit
    import tlah_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tlah_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tlah_out_t                out_data
);

    logic signed [15:0] warn_trip_reg;
    logic signed [15:0] warn_release_reg;
    logic [15:0]        warn_hold_reg;
    logic signed [15:0] crit_trip_reg;
    logic signed [15:0] crit_release_reg;
    logic [15:0]        crit_hold_reg;
    logic               crit_latches_reg;
    logic               low_side_reg;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;
    logic [31:0] start_reg;
    logic [31:0] start_next;
    logic        out_valid_reg;
    tlah_out_t   out_reg;

    logic        accept;
    logic [2:0]  eff_phase;
    logic        crit;
    logic [31:0] elapsed;

    function automatic logic f_tripped(input logic signed [15:0] v,
                                       input logic signed [15:0] thr,
                                       input logic low);
        f_tripped = low ? (v <= thr) : (v >= thr);
    endfunction

    function automatic logic f_released(input logic signed [15:0] v,
                                        input logic signed [15:0] thr,
                                        input logic low);
        f_released = low ? (v >= thr) : (v <= thr);
    endfunction

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_trip_reg    <= '0;
            warn_release_reg <= '0;
            warn_hold_reg    <= '0;
            crit_trip_reg    <= '0;
            crit_release_reg <= '0;
            crit_hold_reg    <= '0;
            crit_latches_reg <= 1'b0;
            low_side_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WARN_TRIP:     warn_trip_reg    <= cfg_data;
                REG_WARN_RELEASE:  warn_release_reg <= cfg_data;
                REG_WARN_HOLD_MS:  warn_hold_reg    <= cfg_data;
                REG_CRIT_TRIP:     crit_trip_reg    <= cfg_data;
                REG_CRIT_RELEASE:  crit_release_reg <= cfg_data;
                REG_CRIT_HOLD_MS:  crit_hold_reg    <= cfg_data;
                REG_CRIT_LATCHES:  crit_latches_reg <= cfg_data[0];
                REG_TRIP_LOW_SIDE: low_side_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // A rearm clears level and start time before the armed checks run.
    assign eff_phase = (phase_reg == PH_DISARMED) ? PH_ARMED : phase_reg;
    assign crit      = (phase_reg != PH_DISARMED) && (level_reg == LV_CRIT);
    assign elapsed   = in_data.time_ms - start_reg;

    always_comb
    begin
        phase_next = eff_phase;
        level_next = (phase_reg == PH_DISARMED) ? LV_NONE : level_reg;
        start_next = (phase_reg == PH_DISARMED) ? 32'd0 : start_reg;
        if (!in_data.enabled)
        begin
            phase_next = PH_DISARMED;
            level_next = LV_NONE;
            start_next = 32'd0;
        end
        else
        begin
            case (eff_phase)
                PH_ARMED:
                begin
                    if (f_tripped(in_data.sample, crit_trip_reg, low_side_reg))
                    begin
                        phase_next = PH_PENDING;
                        level_next = LV_CRIT;
                        start_next = in_data.time_ms;
                    end
                    else if (f_tripped(in_data.sample, warn_trip_reg, low_side_reg))
                    begin
                        phase_next = PH_PENDING;
                        level_next = LV_WARN;
                        start_next = in_data.time_ms;
                    end
                end
                PH_PENDING:
                begin
                    if (f_tripped(in_data.sample, crit ? crit_trip_reg : warn_trip_reg,
                                  low_side_reg))
                    begin
                        if (elapsed >= {16'd0, crit ? crit_hold_reg : warn_hold_reg})
                        begin
                            phase_next = PH_ACTIVE;
                        end
                    end
                    else
                    begin
                        phase_next = PH_ARMED;
                        level_next = LV_NONE;
                    end
                end
                PH_ACTIVE:
                begin
                    if (crit)
                    begin
                        if (!crit_latches_reg &&
                            f_released(in_data.sample, crit_release_reg, low_side_reg))
                        begin
                            phase_next = PH_CLEARING;
                            start_next = in_data.time_ms;
                        end
                    end
                    else if (level_reg == LV_WARN)
                    begin
                        if (f_released(in_data.sample, warn_release_reg, low_side_reg))
                        begin
                            phase_next = PH_CLEARING;
                            start_next = in_data.time_ms;
                        end
                    end
                end
                PH_CLEARING:
                begin
                    if (f_released(in_data.sample,
                                   crit ? crit_release_reg : warn_release_reg,
                                   low_side_reg))
                    begin
                        phase_next = PH_ARMED;
                        level_next = LV_NONE;
                    end
                    else
                    begin
                        phase_next = PH_ACTIVE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DISARMED;
            level_reg     <= LV_NONE;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                level_reg     <= level_next;
                start_reg     <= start_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg.alert_level <= level_next;
            out_reg.alert_phase <= phase_next;
        end
    end

    a_accept_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    a_disarm_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in_data.enabled |=>
            out_data.alert_phase == PH_DISARMED && out_data.alert_level == LV_NONE)
        else $error("disarm did not clear the alarm");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.alert_phase == phase_reg && out_data.alert_level == level_reg)
        else $error("result word differs from the alarm state");

    a_armed_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ARMED || phase_reg == PH_DISARMED |-> level_reg == LV_NONE)
        else $error("level set while armed or disarmed");

    a_disarmed_timer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DISARMED |-> start_reg == 32'd0)
        else $error("start time kept while disarmed");

endmodule
